// ===== design/fbs_pkg.sv =====
// Package for the fan bank supervisor: shared types, codes and constants.
// Used by fbs_front, fbs_engine and the top level; no dependencies.
package fbs_pkg;

  localparam int unsigned FANS_DEF = 4;
  localparam int unsigned DUTY_MAX = 1000;

  typedef enum logic [2:0] {
    ACT_SET_DUTY   = 3'd0,
    ACT_SET_ALL    = 3'd1,
    ACT_SET_TARGET = 3'd2,
    ACT_RAMP       = 3'd3,
    ACT_SAFE       = 3'd4,
    ACT_TASK       = 3'd5
  } action_t;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_CMD, S_FAN, S_PCT, S_CMP, S_OUT
  } eng_state_t;

  localparam logic [1:0] ST_OFF = 2'd0;
  localparam logic [1:0] ST_STARTING = 2'd1;
  localparam logic [1:0] ST_RUNNING = 2'd2;
  localparam logic [1:0] ST_ERROR = 2'd3;

  localparam logic [2:0] AC_NONE = 3'd0;
  localparam logic [2:0] AC_IDLE = 3'd1;
  localparam logic [2:0] AC_DETECT = 3'd2;
  localparam logic [2:0] AC_ACCEL = 3'd3;
  localparam logic [2:0] AC_DECEL = 3'd4;
  localparam logic [2:0] AC_RAMP = 3'd5;

  localparam logic [1:0] AL_NONE = 2'd0;
  localparam logic [1:0] AL_WARN = 2'd1;
  localparam logic [1:0] AL_FAULT = 2'd2;

  localparam logic [2:0] REG_RUN_MIN = 3'd0;
  localparam logic [2:0] REG_TIMEOUT = 3'd1;
  localparam logic [2:0] REG_RAMP_INC = 3'd2;
  localparam logic [2:0] REG_RAMP_INT = 3'd3;
  localparam logic [2:0] REG_PWM_TOP = 3'd4;
  localparam logic [2:0] REG_DELTA = 3'd5;
  localparam logic [2:0] REG_FLOOR = 3'd6;

  typedef struct packed {
    logic [2:0]  action;
    logic [1:0]  fan_index;
    logic [9:0]  duty_value;
    logic [15:0] target_speed_in;
    logic [15:0] max_speed_in;
    logic [31:0] time_ms;
    logic [63:0] tach;
    logic [3:0]  tach_present;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  which_fan;
    logic [1:0]  fan_state;
    logic [2:0]  fan_activity;
    logic [1:0]  fan_alert;
    logic [15:0] reported_speed;
    logic [15:0] target_speed;
    logic [6:0]  duty_percent;
    logic [15:0] pwm_compare;
    logic        ramp_running;
    logic        any_fault;
    logic        last_of_run;
  } status_t;

  typedef struct packed {
    logic [15:0] running_min_speed;
    logic [15:0] startup_timeout;
    logic [9:0]  ramp_increment;
    logic [15:0] ramp_interval;
    logic [15:0] pwm_top;
    logic [15:0] speed_delta;
    logic [9:0]  min_duty_floor;
  } cfg_t;

endpackage

// ===== design/fbs_if.sv =====
// Valid/ready channel interfaces for commands and status results.
// No dependencies.
interface fbs_cmd_if;
  logic valid;
  logic ready;
  logic [2:0]  action;
  logic [1:0]  fan_index;
  logic [9:0]  duty_value;
  logic [15:0] target_speed_in;
  logic [15:0] max_speed_in;
  logic [31:0] time_ms;
  logic [15:0] tach_speed_0;
  logic [15:0] tach_speed_1;
  logic [15:0] tach_speed_2;
  logic [15:0] tach_speed_3;
  logic [3:0]  tach_present;
  modport source (output valid, action, fan_index, duty_value, target_speed_in,
    max_speed_in, time_ms, tach_speed_0, tach_speed_1, tach_speed_2, tach_speed_3,
    tach_present, input ready);
  modport sink (input valid, action, fan_index, duty_value, target_speed_in,
    max_speed_in, time_ms, tach_speed_0, tach_speed_1, tach_speed_2, tach_speed_3,
    tach_present, output ready);
endinterface

interface fbs_stat_if;
  logic valid;
  logic ready;
  logic [1:0]  which_fan;
  logic [1:0]  fan_state;
  logic [2:0]  fan_activity;
  logic [1:0]  fan_alert;
  logic [15:0] reported_speed;
  logic [15:0] target_speed;
  logic [6:0]  duty_percent;
  logic [15:0] pwm_compare;
  logic        ramp_running;
  logic        any_fault;
  logic        last_of_run;
  modport source (output valid, which_fan, fan_state, fan_activity, fan_alert,
    reported_speed, target_speed, duty_percent, pwm_compare, ramp_running,
    any_fault, last_of_run, input ready);
  modport sink (input valid, which_fan, fan_state, fan_activity, fan_alert,
    reported_speed, target_speed, duty_percent, pwm_compare, ramp_running,
    any_fault, last_of_run, output ready);
endinterface

// ===== design/fbs_front.sv =====
// Front end: accepts commands into a two-entry queue for the engine.
// Depends on fbs_pkg.
module fbs_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  fbs_pkg::cmd_t   in_cmd,
  output logic            q_valid,
  input  logic            q_pop,
  output fbs_pkg::cmd_t   q_cmd
);
  fbs_pkg::cmd_t slot [2];
  logic rd_ptr, wr_ptr;
  logic [1:0] count;
  logic push;

  assign in_ready = (count != 2'd2);
  assign push = in_valid && in_ready;
  assign q_valid = (count != 2'd0);
  assign q_cmd = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= in_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule

// ===== design/fbs_divider.sv =====
// Restoring serial divider, one quotient bit per cycle.
// No dependencies.
module fbs_divider #(
  parameter int unsigned NW = 32,
  parameter int unsigned DW = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quot
);
  localparam int unsigned CW = $clog2(NW + 1);
  logic [DW:0]   rem;
  logic [NW-1:0] q;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [DW:0]   trial;
  logic [DW-1:0] dreg;

  assign trial = {rem[DW-1:0], q[NW-1]};
  assign quot = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CW'(NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      q <= num;
      dreg <= den;
    end else if (busy) begin
      if (trial >= {1'b0, dreg}) begin
        rem <= trial - {1'b0, dreg};
        q <= {q[NW-2:0], 1'b1};
      end else begin
        rem <= trial;
        q <= {q[NW-2:0], 1'b0};
      end
    end
  end
endmodule

// ===== design/fbs_engine.sv =====
// Back end: carries out a command, on a task item updates fan state one fan
// per cycle, then emits one status per fan. Depends on fbs_pkg, fbs_divider.
module fbs_engine #(
  parameter int unsigned FANS = fbs_pkg::FANS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  fbs_pkg::cfg_t    cfg,
  input  logic             q_valid,
  output logic             q_pop,
  input  fbs_pkg::cmd_t    q_cmd,
  output logic             out_valid,
  input  logic             out_ready,
  output fbs_pkg::status_t out_stat
);
  localparam int unsigned FW = (FANS > 1) ? $clog2(FANS) : 1;
  // x/1000 = (x>>3)/125; ceil(2^30/125) is exact for x>>3 below 2^24
  localparam logic [23:0] RECIP_125 = 24'd8589935;

  fbs_pkg::eng_state_t st, st_next;
  fbs_pkg::cmd_t cmd;
  logic [FW-1:0] fi;

  logic [9:0]  duty_store [FANS];
  logic [15:0] prev_speed [FANS];
  logic [31:0] cmd_time [FANS];
  logic        seen [FANS];
  logic [1:0]  state_store [FANS];
  logic [2:0]  act_store [FANS];
  logic [1:0]  alert_store [FANS];
  logic [15:0] speed_store [FANS];
  logic [15:0] target_store [FANS];
  logic        ramp_on;
  logic [10:0] ramp_level;
  logic [31:0] ramp_due;

  logic        div_start, div_done;
  logic [31:0] div_num, div_q;
  logic [15:0] div_den;
  logic [9:0]  tgt_duty;
  logic [15:0] cmp_reg;
  logic [6:0]  pct_reg;
  logic [26:0] cmp_prod;
  logic [47:0] cmp_recip;
  logic [16:0] cmp_quot;

  fbs_divider #(.NW(32), .DW(16)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quot(div_q)
  );

  // next state
  always_comb begin
    st_next = st;
    case (st)
      fbs_pkg::S_IDLE: if (q_valid) st_next = fbs_pkg::S_DIV;
      fbs_pkg::S_DIV:
        if (cmd.action != fbs_pkg::ACT_SET_TARGET || div_done) st_next = fbs_pkg::S_CMD;
      fbs_pkg::S_CMD:
        st_next = (cmd.action == fbs_pkg::ACT_TASK) ? fbs_pkg::S_FAN : fbs_pkg::S_PCT;
      fbs_pkg::S_FAN: if (fi == FW'(FANS - 1)) st_next = fbs_pkg::S_PCT;
      fbs_pkg::S_PCT: st_next = fbs_pkg::S_CMP;
      fbs_pkg::S_CMP: st_next = fbs_pkg::S_OUT;
      fbs_pkg::S_OUT:
        if (out_ready) st_next = (fi == FW'(FANS - 1)) ? fbs_pkg::S_IDLE : fbs_pkg::S_PCT;
      default: st_next = fbs_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop = (st == fbs_pkg::S_IDLE) && q_valid;
    out_valid = (st == fbs_pkg::S_OUT);
  end

  always_ff @(posedge clk) begin
    if (rst) st <= fbs_pkg::S_IDLE;
    else st <= st_next;
  end

  // divider runs only for the target duty of set-target commands
  always_comb begin
    div_start = q_pop && (q_cmd.action == fbs_pkg::ACT_SET_TARGET);
    div_num = {16'd0, q_cmd.target_speed_in} * 32'd1000;
    div_den = q_cmd.max_speed_in;
  end

  always_comb begin
    tgt_duty = 10'd1000;
    if (div_q < {22'd0, cfg.min_duty_floor}) tgt_duty = cfg.min_duty_floor;
    else if (div_q <= 32'd1000) tgt_duty = div_q[9:0];
    if (tgt_duty > 10'd1000) tgt_duty = 10'd1000;
  end
  logic [9:0] tgt_latched;

  logic [9:0] dclamp;
  assign dclamp = (cmd.duty_value > 10'd1000) ? 10'd1000 : cmd.duty_value;
  logic [9:0] rclamp;
  assign rclamp = (ramp_level > 11'd1000) ? 10'd1000 : ramp_level[9:0];

  assign cmp_recip = {24'd0, cmp_prod[26:3]} * {24'd0, RECIP_125};
  assign cmp_quot = cmp_recip[46:30];

  // per-fan update signals
  logic [15:0] tach_f, prev_f, sum_w;
  logic        pres_f;
  logic [16:0] tsum;
  logic [31:0] elapsed;
  assign tach_f = cmd.tach[16*fi +: 16];
  assign pres_f = cmd.tach_present[fi];
  assign prev_f = prev_speed[fi];
  assign sum_w = prev_f + cfg.speed_delta;
  assign tsum = {1'b0, tach_f} + {1'b0, cfg.speed_delta};
  assign elapsed = cmd.time_ms - cmd_time[fi];

  logic fault;
  always_comb begin
    fault = 1'b0;
    for (int i = 0; i < FANS; i++) if (state_store[i] == fbs_pkg::ST_ERROR) fault = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (q_pop) cmd <= q_cmd;
    if (st == fbs_pkg::S_DIV && div_done) tgt_latched <= tgt_duty;
    if (st == fbs_pkg::S_PCT) begin
      cmp_prod <= ({11'd0, cfg.pwm_top} + 27'd1) * {17'd0, duty_store[fi]};
      pct_reg <= (duty_store[fi] >= 10'd995) ? 7'd100 :
                 7'((({8'd0, duty_store[fi]} + 18'd5) * 18'd205) >> 11);
    end
    if (st == fbs_pkg::S_CMP)
      cmp_reg <= (cmp_quot > {1'b0, cfg.pwm_top}) ? cfg.pwm_top : cmp_quot[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fi <= '0;
      ramp_on <= 1'b0;
      ramp_level <= '0;
      ramp_due <= '0;
      for (int i = 0; i < FANS; i++) begin
        duty_store[i] <= '0; prev_speed[i] <= '0; cmd_time[i] <= '0;
        seen[i] <= 1'b0; state_store[i] <= fbs_pkg::ST_OFF;
        act_store[i] <= fbs_pkg::AC_NONE; alert_store[i] <= fbs_pkg::AL_NONE;
        speed_store[i] <= '0; target_store[i] <= '0;
      end
    end else begin
      case (st)
        fbs_pkg::S_IDLE: fi <= '0;
        fbs_pkg::S_CMD: begin
          case (cmd.action)
            fbs_pkg::ACT_SET_DUTY: if ({30'd0, cmd.fan_index} < 32'(FANS)) begin
              duty_store[FW'(cmd.fan_index)] <= dclamp;
              cmd_time[FW'(cmd.fan_index)] <= cmd.time_ms;
              if (dclamp == 10'd0) begin
                seen[FW'(cmd.fan_index)] <= 1'b0;
                target_store[FW'(cmd.fan_index)] <= '0;
              end
            end
            fbs_pkg::ACT_SET_ALL: begin
              if (ramp_on && {1'b0, dclamp} != ramp_level) ramp_on <= 1'b0;
              for (int i = 0; i < FANS; i++) begin
                duty_store[i] <= dclamp;
                cmd_time[i] <= cmd.time_ms;
                if (dclamp == 10'd0) begin
                  seen[i] <= 1'b0;
                  target_store[i] <= '0;
                end
              end
            end
            fbs_pkg::ACT_SET_TARGET: if ({30'd0, cmd.fan_index} < 32'(FANS)) begin
              cmd_time[FW'(cmd.fan_index)] <= cmd.time_ms;
              if (cmd.target_speed_in == 16'd0 || cmd.max_speed_in == 16'd0) begin
                duty_store[FW'(cmd.fan_index)] <= '0;
                seen[FW'(cmd.fan_index)] <= 1'b0;
                target_store[FW'(cmd.fan_index)] <= '0;
              end else begin
                duty_store[FW'(cmd.fan_index)] <= tgt_latched;
                // zero floor can still yield a zero duty, which acts as a stop
                if (tgt_latched == 10'd0) begin
                  seen[FW'(cmd.fan_index)] <= 1'b0;
                  target_store[FW'(cmd.fan_index)] <= '0;
                end else begin
                  target_store[FW'(cmd.fan_index)] <= cmd.target_speed_in;
                end
              end
            end
            fbs_pkg::ACT_RAMP: begin
              ramp_on <= 1'b1;
              ramp_level <= '0;
              ramp_due <= cmd.time_ms;
            end
            fbs_pkg::ACT_SAFE: begin
              ramp_on <= 1'b0;
              for (int i = 0; i < FANS; i++) begin
                duty_store[i] <= '0;
                cmd_time[i] <= cmd.time_ms;
                seen[i] <= 1'b0;
                target_store[i] <= '0;
              end
            end
            fbs_pkg::ACT_TASK: if (ramp_on && cmd.time_ms >= ramp_due) begin
              for (int i = 0; i < FANS; i++) begin
                duty_store[i] <= rclamp;
                cmd_time[i] <= cmd.time_ms;
                if (rclamp == 10'd0) begin
                  seen[i] <= 1'b0;
                  target_store[i] <= '0;
                end
              end
              if (ramp_level >= 11'd1000) ramp_on <= 1'b0;
              else begin
                ramp_level <= ramp_level + {1'b0, cfg.ramp_increment};
                ramp_due <= cmd.time_ms + {16'd0, cfg.ramp_interval};
              end
            end
            default: ;
          endcase
        end
        fbs_pkg::S_FAN: begin
          alert_store[fi] <= fbs_pkg::AL_NONE;
          if (duty_store[fi] == 10'd0) begin
            state_store[fi] <= fbs_pkg::ST_OFF;
            act_store[fi] <= fbs_pkg::AC_NONE;
            speed_store[fi] <= '0;
            target_store[fi] <= '0;
            prev_speed[fi] <= '0;
          end else begin
            speed_store[fi] <= tach_f;
            prev_speed[fi] <= tach_f;
            if (pres_f && tach_f >= cfg.running_min_speed) begin
              state_store[fi] <= fbs_pkg::ST_RUNNING;
              seen[fi] <= 1'b1;
              if (tach_f > sum_w)
                act_store[fi] <= ramp_on ? fbs_pkg::AC_RAMP : fbs_pkg::AC_ACCEL;
              else if (prev_f > cfg.speed_delta && tsum < {1'b0, prev_f})
                act_store[fi] <= fbs_pkg::AC_DECEL;
              else
                act_store[fi] <= fbs_pkg::AC_IDLE;
            end else if (elapsed <= {16'd0, cfg.startup_timeout}) begin
              state_store[fi] <= fbs_pkg::ST_STARTING;
              act_store[fi] <= fbs_pkg::AC_DETECT;
            end else begin
              state_store[fi] <= fbs_pkg::ST_ERROR;
              act_store[fi] <= fbs_pkg::AC_DETECT;
              alert_store[fi] <= seen[fi] ? fbs_pkg::AL_FAULT : fbs_pkg::AL_WARN;
            end
          end
          fi <= (fi == FW'(FANS - 1)) ? '0 : FW'(fi + 1'b1);
        end
        fbs_pkg::S_OUT: if (out_ready) fi <= (fi == FW'(FANS - 1)) ? '0 : FW'(fi + 1'b1);
        default: ;
      endcase
    end
  end

  always_comb begin
    out_stat.which_fan = 2'(fi);
    out_stat.fan_state = state_store[fi];
    out_stat.fan_activity = act_store[fi];
    out_stat.fan_alert = alert_store[fi];
    out_stat.reported_speed = speed_store[fi];
    out_stat.target_speed = target_store[fi];
    out_stat.duty_percent = pct_reg;
    out_stat.pwm_compare = cmp_reg;
    out_stat.ramp_running = ramp_on;
    out_stat.any_fault = fault;
    out_stat.last_of_run = (fi == FW'(FANS - 1));
  end
endmodule

// ===== design/fan_bank_supervisor_top.sv =====
// Top level of the fan bank supervisor: configuration registers, command
// queue and engine. Depends on fbs_pkg, fbs_if, fbs_front, fbs_engine.
//
// In the engine each command is taken from the queue, passes the divider
// state and is carried out, then per fan the duty product, the PWM compare
// and the status are produced in turn. A task item first updates the fans
// one at a time, and a set-target command waits in the divider state for the
// serial divider that computes its duty. A two-entry command queue accepts
// new commands while the engine works, and statuses leave one per transfer,
// fan 0 first.
module fan_bank_supervisor_top #(
  parameter int unsigned FANS = fbs_pkg::FANS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  fbs_cmd_if.sink     cmd,
  fbs_stat_if.source  stat
);
  fbs_pkg::cfg_t cfg;
  fbs_pkg::cmd_t in_cmd, q_cmd;
  fbs_pkg::status_t st;
  logic q_valid, q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.running_min_speed <= 16'd200;
      cfg.startup_timeout <= 16'd1500;
      cfg.ramp_increment <= 10'd50;
      cfg.ramp_interval <= 16'd250;
      cfg.pwm_top <= 16'd319;
      cfg.speed_delta <= 16'd50;
      cfg.min_duty_floor <= 10'd150;
    end else if (cfg_we) begin
      case (cfg_index)
        fbs_pkg::REG_RUN_MIN: cfg.running_min_speed <= cfg_data;
        fbs_pkg::REG_TIMEOUT: cfg.startup_timeout <= cfg_data;
        fbs_pkg::REG_RAMP_INC: cfg.ramp_increment <= cfg_data[9:0];
        fbs_pkg::REG_RAMP_INT: cfg.ramp_interval <= cfg_data;
        fbs_pkg::REG_PWM_TOP: cfg.pwm_top <= cfg_data;
        fbs_pkg::REG_DELTA: cfg.speed_delta <= cfg_data;
        fbs_pkg::REG_FLOOR: cfg.min_duty_floor <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    in_cmd.action = cmd.action;
    in_cmd.fan_index = cmd.fan_index;
    in_cmd.duty_value = cmd.duty_value;
    in_cmd.target_speed_in = cmd.target_speed_in;
    in_cmd.max_speed_in = cmd.max_speed_in;
    in_cmd.time_ms = cmd.time_ms;
    in_cmd.tach = {cmd.tach_speed_3, cmd.tach_speed_2, cmd.tach_speed_1,
                   cmd.tach_speed_0};
    in_cmd.tach_present = cmd.tach_present;
  end

  fbs_front u_front (
    .clk(clk), .rst(rst), .in_valid(cmd.valid), .in_ready(cmd.ready),
    .in_cmd(in_cmd), .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd)
  );

  fbs_engine #(.FANS(FANS)) u_engine (
    .clk(clk), .rst(rst), .cfg(cfg), .q_valid(q_valid), .q_pop(q_pop),
    .q_cmd(q_cmd), .out_valid(stat.valid), .out_ready(stat.ready), .out_stat(st)
  );

  assign stat.which_fan = st.which_fan;
  assign stat.fan_state = st.fan_state;
  assign stat.fan_activity = st.fan_activity;
  assign stat.fan_alert = st.fan_alert;
  assign stat.reported_speed = st.reported_speed;
  assign stat.target_speed = st.target_speed;
  assign stat.duty_percent = st.duty_percent;
  assign stat.pwm_compare = st.pwm_compare;
  assign stat.ramp_running = st.ramp_running;
  assign stat.any_fault = st.any_fault;
  assign stat.last_of_run = st.last_of_run;
endmodule

// ===== tb/sv/tb_fbs_if.sv =====
`timescale 1ns / 1ps
// Testbench copy point for the command and status channel interfaces.
// The interfaces themselves live in the design folder (fbs_if.sv); this file
// only groups the channel helpers used by the testbench top. Depends on fbs_pkg.
package tb_fbs_chan_pkg;
  import fbs_pkg::*;

  // One expected status transfer.
  typedef struct {
    logic [1:0]  which_fan;
    logic [1:0]  fan_state;
    logic [2:0]  fan_activity;
    logic [1:0]  fan_alert;
    logic [15:0] reported_speed;
    logic [15:0] target_speed;
    logic [6:0]  duty_percent;
    logic [15:0] pwm_compare;
    logic        ramp_running;
    logic        any_fault;
    logic        last_of_run;
  } fan_status_t;
endpackage

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Testbench for fan_bank_supervisor_top: directed table then random commands,
// every status transfer checked against a behavioral fan bank model.
// Depends on fbs_pkg, tb_fbs_chan_pkg, fbs_if and the block's RTL.
module tb;
  import fbs_pkg::*;
  import tb_fbs_chan_pkg::*;

  localparam int NFAN = 4;
  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  fbs_cmd_if cmd ();
  fbs_stat_if stat ();

  fan_bank_supervisor_top dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .cmd(cmd.sink), .stat(stat.source)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // model state
  logic [15:0] m_run_min, m_timeout, m_ramp_int, m_top, m_delta;
  logic [9:0]  m_ramp_inc, m_floor;
  logic [9:0]  m_duty [NFAN];
  logic [15:0] m_prev [NFAN];
  logic [31:0] m_cmd_time [NFAN];
  logic        m_seen [NFAN];
  logic [1:0]  m_state [NFAN];
  logic [2:0]  m_act [NFAN];
  logic [1:0]  m_alert [NFAN];
  logic [15:0] m_speed [NFAN];
  logic [15:0] m_target [NFAN];
  logic        m_ramp_on;
  logic [10:0] m_ramp_level;
  logic [31:0] m_ramp_due;

  fan_status_t status_q[$];
  int errors = 0;
  int items_sent = 0;
  int stat_seen = 0;
  int idle_src = 0, idle_snk = 0;
  int stall_cnt = 0;

  typedef struct {
    logic [2:0]  action;
    logic [1:0]  fan_index;
    logic [9:0]  duty_value;
    logic [15:0] tgt, mx;
    logic [31:0] time_ms;
    logic [15:0] tach [NFAN];
    logic [3:0]  present;
  } fan_cmd_t;

  task automatic model_reset();
    m_run_min = 16'd200; m_timeout = 16'd1500; m_ramp_inc = 10'd50;
    m_ramp_int = 16'd250; m_top = 16'd319; m_delta = 16'd50; m_floor = 10'd150;
    for (int f = 0; f < NFAN; f++) begin
      m_duty[f] = '0; m_prev[f] = '0; m_cmd_time[f] = '0; m_seen[f] = 1'b0;
      m_state[f] = ST_OFF; m_act[f] = AC_NONE; m_alert[f] = AL_NONE;
      m_speed[f] = '0; m_target[f] = '0;
    end
    m_ramp_on = 1'b0; m_ramp_level = '0; m_ramp_due = '0;
  endtask

  task automatic fan_set_duty(int f, int unsigned duty, logic [31:0] now);
    if (duty > DUTY_MAX) duty = DUTY_MAX;
    m_duty[f] = duty[9:0];
    m_cmd_time[f] = now;
    if (duty == 0) begin
      m_seen[f] = 1'b0;
      m_target[f] = '0;
    end
  endtask

  task automatic fan_set_every(int unsigned duty, logic [31:0] now);
    if (duty > DUTY_MAX) duty = DUTY_MAX;
    if (m_ramp_on && duty != m_ramp_level) m_ramp_on = 1'b0;
    for (int f = 0; f < NFAN; f++) fan_set_duty(f, duty, now);
  endtask

  task automatic fan_classify(int f, logic [15:0] tach, logic present, logic [31:0] now);
    logic [15:0] lim;
    logic [31:0] elapsed;
    m_alert[f] = AL_NONE;
    if (m_duty[f] == 0) begin
      m_state[f] = ST_OFF; m_act[f] = AC_NONE; m_speed[f] = '0;
      m_target[f] = '0; m_prev[f] = '0;
    end else begin
      m_speed[f] = tach;
      elapsed = now - m_cmd_time[f];
      if (present && tach >= m_run_min) begin
        lim = m_prev[f] + m_delta;
        m_state[f] = ST_RUNNING;
        m_seen[f] = 1'b1;
        if (tach > lim) m_act[f] = m_ramp_on ? AC_RAMP : AC_ACCEL;
        else if (m_prev[f] > m_delta && 17'(tach) + 17'(m_delta) < 17'(m_prev[f]))
          m_act[f] = AC_DECEL;
        else m_act[f] = AC_IDLE;
      end else if (elapsed <= 32'(m_timeout)) begin
        m_state[f] = ST_STARTING; m_act[f] = AC_DETECT;
      end else begin
        m_state[f] = ST_ERROR; m_act[f] = AC_DETECT;
        m_alert[f] = m_seen[f] ? AL_FAULT : AL_WARN;
      end
      m_prev[f] = tach;
    end
  endtask

  // apply one command to the model and queue its four status transfers
  task automatic fan_bank_predict(fan_cmd_t c);
    int unsigned d;
    logic fault;
    fan_status_t s;
    case (c.action)
      ACT_SET_DUTY: fan_set_duty(c.fan_index, c.duty_value, c.time_ms);
      ACT_SET_ALL: fan_set_every(c.duty_value, c.time_ms);
      ACT_SET_TARGET: begin
        m_target[c.fan_index] = c.tgt;
        if (c.tgt == 0 || c.mx == 0) fan_set_duty(c.fan_index, 0, c.time_ms);
        else begin
          d = (32'(c.tgt) * 1000) / 32'(c.mx);
          if (d < m_floor) d = m_floor;
          if (d > DUTY_MAX) d = DUTY_MAX;
          fan_set_duty(c.fan_index, d, c.time_ms);
        end
      end
      ACT_RAMP: begin
        m_ramp_on = 1'b1; m_ramp_level = '0; m_ramp_due = c.time_ms;
      end
      ACT_SAFE: begin
        m_ramp_on = 1'b0;
        for (int f = 0; f < NFAN; f++) m_target[f] = '0;
        fan_set_every(0, c.time_ms);
      end
      ACT_TASK: begin
        if (m_ramp_on && c.time_ms >= m_ramp_due) begin
          fan_set_every(m_ramp_level, c.time_ms);
          if (m_ramp_level >= DUTY_MAX) m_ramp_on = 1'b0;
          else begin
            m_ramp_level = m_ramp_level + 11'(m_ramp_inc);
            m_ramp_due = c.time_ms + 32'(m_ramp_int);
          end
        end
        for (int f = 0; f < NFAN; f++) fan_classify(f, c.tach[f], c.present[f], c.time_ms);
      end
      default: ;
    endcase
    fault = 1'b0;
    for (int f = 0; f < NFAN; f++) if (m_state[f] == ST_ERROR) fault = 1'b1;
    for (int f = 0; f < NFAN; f++) begin
      logic [31:0] pct, cmpv;
      pct = (32'(m_duty[f]) + 5) / 10;
      cmpv = ((32'(m_top) + 1) * 32'(m_duty[f])) / DUTY_MAX;
      if (pct > 100) pct = 100;
      if (cmpv > 32'(m_top)) cmpv = 32'(m_top);
      s.which_fan = f[1:0]; s.fan_state = m_state[f]; s.fan_activity = m_act[f];
      s.fan_alert = m_alert[f]; s.reported_speed = m_speed[f];
      s.target_speed = m_target[f]; s.duty_percent = pct[6:0];
      s.pwm_compare = cmpv[15:0]; s.ramp_running = m_ramp_on;
      s.any_fault = fault; s.last_of_run = (f == NFAN - 1);
      status_q.push_back(s);
    end
  endtask

  task automatic chk_field(string name, logic [31:0] exp, logic [31:0] got);
    if (got !== exp) begin
      $error("%s exp %0d got %0d", name, exp, got);
      errors++;
    end
  endtask

  // status sink: random stall, compare each transfer
  always @(posedge clk) begin
    if (rst) stat.ready <= 1'b0;
    else stat.ready <= ($urandom_range(99) >= idle_snk);
    if (!rst && stat.valid && stat.ready) begin
      fan_status_t e;
      stat_seen++;
      // first item after reset: every fan reads plainly off
      if (stat_seen <= NFAN) begin
        chk_field("fan_state", 32'(ST_OFF), 32'(stat.fan_state));
        chk_field("fan_activity", 32'(AC_NONE), 32'(stat.fan_activity));
        chk_field("fan_alert", 32'(AL_NONE), 32'(stat.fan_alert));
        chk_field("reported_speed", 32'd0, 32'(stat.reported_speed));
        chk_field("target_speed", 32'd0, 32'(stat.target_speed));
        chk_field("duty_percent", 32'd0, 32'(stat.duty_percent));
        chk_field("pwm_compare", 32'd0, 32'(stat.pwm_compare));
        chk_field("ramp_running", 32'd0, 32'(stat.ramp_running));
        chk_field("any_fault", 32'd0, 32'(stat.any_fault));
      end
      if (status_q.size() == 0) begin
        $error("status transfer with nothing expected (fan %0d)", stat.which_fan);
        errors++;
      end else begin
        e = status_q.pop_front();
        if (stat.which_fan !== e.which_fan) begin
          $error("which_fan exp %0d got %0d", e.which_fan, stat.which_fan); errors++; end
        if (stat.fan_state !== e.fan_state) begin
          $error("fan_state exp %0d got %0d", e.fan_state, stat.fan_state); errors++; end
        if (stat.fan_activity !== e.fan_activity) begin
          $error("fan_activity exp %0d got %0d", e.fan_activity, stat.fan_activity);
          errors++;
        end
        if (stat.fan_alert !== e.fan_alert) begin
          $error("fan_alert exp %0d got %0d", e.fan_alert, stat.fan_alert); errors++; end
        if (stat.reported_speed !== e.reported_speed) begin
          $error("reported_speed exp %0d got %0d", e.reported_speed, stat.reported_speed);
          errors++;
        end
        if (stat.target_speed !== e.target_speed) begin
          $error("target_speed exp %0d got %0d", e.target_speed, stat.target_speed);
          errors++;
        end
        if (stat.duty_percent !== e.duty_percent) begin
          $error("duty_percent exp %0d got %0d", e.duty_percent, stat.duty_percent);
          errors++;
        end
        if (stat.pwm_compare !== e.pwm_compare) begin
          $error("pwm_compare exp %0d got %0d", e.pwm_compare, stat.pwm_compare);
          errors++;
        end
        if (stat.ramp_running !== e.ramp_running) begin
          $error("ramp_running exp %0d got %0d", e.ramp_running, stat.ramp_running);
          errors++;
        end
        if (stat.any_fault !== e.any_fault) begin
          $error("any_fault exp %0d got %0d", e.any_fault, stat.any_fault); errors++; end
        if (stat.last_of_run !== e.last_of_run) begin
          $error("last_of_run exp %0d got %0d", e.last_of_run, stat.last_of_run);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (cmd.valid && cmd.ready) || (stat.valid && stat.ready)) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // valid stays high into the next command unless the sender idles
  task automatic send_cmd(fan_cmd_t c);
    while ($urandom_range(99) < idle_src) begin
      cmd.valid <= 1'b0;
      @(posedge clk);
    end
    cmd.valid <= 1'b1;
    cmd.action <= c.action; cmd.fan_index <= c.fan_index; cmd.duty_value <= c.duty_value;
    cmd.target_speed_in <= c.tgt; cmd.max_speed_in <= c.mx; cmd.time_ms <= c.time_ms;
    cmd.tach_speed_0 <= c.tach[0]; cmd.tach_speed_1 <= c.tach[1];
    cmd.tach_speed_2 <= c.tach[2]; cmd.tach_speed_3 <= c.tach[3];
    cmd.tach_present <= c.present;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    fan_bank_predict(c);
    items_sent++;
  endtask

  task automatic drain();
    cmd.valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_RUN_MIN: m_run_min = val;
      REG_TIMEOUT: m_timeout = val;
      REG_RAMP_INC: m_ramp_inc = val[9:0];
      REG_RAMP_INT: m_ramp_int = val;
      REG_PWM_TOP: m_top = val;
      REG_DELTA: m_delta = val;
      REG_FLOOR: m_floor = val[9:0];
      default: ;
    endcase
  endtask

  function automatic fan_cmd_t mk(logic [2:0] a, logic [1:0] i, logic [9:0] d,
                                  logic [15:0] t, logic [15:0] m, logic [31:0] now,
                                  logic [15:0] sp, logic [3:0] p);
    fan_cmd_t c;
    c.action = a; c.fan_index = i; c.duty_value = d; c.tgt = t; c.mx = m;
    c.time_ms = now; c.present = p;
    for (int f = 0; f < NFAN; f++) c.tach[f] = sp;
    return c;
  endfunction

  // tracks a clock in milliseconds, mostly advancing, sometimes jumping
  logic [31:0] clock_ms = 32'd0;

  function automatic fan_cmd_t rand_cmd();
    fan_cmd_t c;
    int r;
    r = $urandom_range(99);
    if (r < 40) c.action = ACT_TASK;
    else if (r < 55) c.action = ACT_SET_DUTY;
    else if (r < 65) c.action = ACT_SET_ALL;
    else if (r < 78) c.action = ACT_SET_TARGET;
    else if (r < 86) c.action = ACT_RAMP;
    else if (r < 93) c.action = ACT_SAFE;
    else c.action = 3'($urandom_range(7));
    c.fan_index = 2'($urandom_range(3));
    c.duty_value = ($urandom_range(3) == 0) ? 10'($urandom) : 10'($urandom_range(1000));
    c.tgt = ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(3000));
    c.mx = ($urandom_range(6) == 0) ? 16'd0 : 16'($urandom);
    if ($urandom_range(9) == 0) clock_ms = $urandom;
    else clock_ms = clock_ms + $urandom_range(600);
    c.time_ms = clock_ms;
    for (int f = 0; f < NFAN; f++)
      c.tach[f] = ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(400));
    c.present = 4'($urandom_range(15));
    return c;
  endfunction

  fan_cmd_t dir_tab[$];

  initial begin
    fan_cmd_t c;
    cmd.valid = 1'b0; cmd.action = '0; cmd.fan_index = '0; cmd.duty_value = '0;
    cmd.target_speed_in = '0; cmd.max_speed_in = '0; cmd.time_ms = '0;
    cmd.tach_speed_0 = '0; cmd.tach_speed_1 = '0; cmd.tach_speed_2 = '0;
    cmd.tach_speed_3 = '0; cmd.tach_present = '0;
    model_reset();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    dir_tab.push_back(mk(ACT_TASK, 0, 0, 0, 0, 0, 0, 4'h0));
    dir_tab.push_back(mk(ACT_SET_DUTY, 0, 10'h3FF, 0, 0, 10, 0, 0));
    dir_tab.push_back(mk(ACT_SET_DUTY, 3, 1, 0, 0, 20, 0, 0));
    dir_tab.push_back(mk(ACT_SET_TARGET, 1, 0, 16'hFFFF, 16'hFFFF, 30, 0, 0));
    dir_tab.push_back(mk(ACT_SET_TARGET, 2, 0, 10, 16'hFFFF, 40, 0, 0));
    dir_tab.push_back(mk(ACT_TASK, 0, 0, 0, 0, 100, 16'hFFFF, 4'hF));
    dir_tab.push_back(mk(ACT_TASK, 0, 0, 0, 0, 200, 300, 4'hF));
    dir_tab.push_back(mk(ACT_TASK, 0, 0, 0, 0, 300, 100, 4'h5));
    dir_tab.push_back(mk(ACT_TASK, 0, 0, 0, 0, 5000, 0, 4'h0));
    dir_tab.push_back(mk(ACT_SET_TARGET, 0, 0, 0, 500, 5100, 0, 0));
    dir_tab.push_back(mk(ACT_SET_TARGET, 3, 0, 500, 0, 5200, 0, 0));
    dir_tab.push_back(mk(ACT_RAMP, 0, 0, 0, 0, 32'hFFFF_FF00, 0, 0));
    dir_tab.push_back(mk(ACT_TASK, 0, 0, 0, 0, 32'hFFFF_FF00, 300, 4'hF));
    dir_tab.push_back(mk(ACT_TASK, 0, 0, 0, 0, 32'hFFFF_FFFF, 900, 4'hF));
    dir_tab.push_back(mk(ACT_TASK, 0, 0, 0, 0, 32'h0000_0100, 0, 4'h0));
    dir_tab.push_back(mk(ACT_SET_ALL, 0, 10'd777, 0, 0, 400, 0, 0));
    dir_tab.push_back(mk(3'd6, 0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk(3'd7, 3, 10'h3FF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 0, 4'hF));
    dir_tab.push_back(mk(ACT_SAFE, 0, 0, 0, 0, 600, 0, 0));
    dir_tab.push_back(mk(ACT_TASK, 0, 0, 0, 0, 700, 16'hFFFF, 4'hF));
    foreach (dir_tab[k]) send_cmd(dir_tab[k]);
    drain();

    // phases: register settings and idling mix
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin idle_src = 0; idle_snk = 0; end
        1: begin idle_src = 55; idle_snk = 0; end
        2: begin idle_src = 0; idle_snk = 55; end
        3: begin idle_src = 29; idle_snk = 29; end
        default: begin idle_src = $urandom_range(1) * 29; idle_snk = 0; end
      endcase
      case (ph)
        1: begin
          write_reg(REG_RUN_MIN, 16'd0); write_reg(REG_TIMEOUT, 16'd0);
          write_reg(REG_RAMP_INC, 16'd1000); write_reg(REG_RAMP_INT, 16'd0);
          write_reg(REG_PWM_TOP, 16'd1); write_reg(REG_DELTA, 16'd0);
          write_reg(REG_FLOOR, 16'd0);
        end
        2: begin
          write_reg(REG_RUN_MIN, 16'hFFFF); write_reg(REG_TIMEOUT, 16'hFFFF);
          write_reg(REG_RAMP_INC, 16'd1); write_reg(REG_RAMP_INT, 16'hFFFF);
          write_reg(REG_PWM_TOP, 16'hFFFF); write_reg(REG_DELTA, 16'hFFFF);
          write_reg(REG_FLOOR, 16'd1000);
        end
        3: begin
          write_reg(REG_PWM_TOP, 16'd0); write_reg(REG_RAMP_INC, 16'd0);
          write_reg(REG_RUN_MIN, 16'd100); write_reg(REG_DELTA, 16'd30);
          write_reg(REG_TIMEOUT, 16'd800); write_reg(REG_FLOOR, 16'd300);
          write_reg(REG_RAMP_INT, 16'd50);
        end
        4: begin
          write_reg(REG_RUN_MIN, 16'd200); write_reg(REG_TIMEOUT, 16'd1500);
          write_reg(REG_RAMP_INC, 16'd50); write_reg(REG_RAMP_INT, 16'd250);
          write_reg(REG_PWM_TOP, 16'd319); write_reg(REG_DELTA, 16'd50);
          write_reg(REG_FLOOR, 16'd150);
        end
        default: ;
      endcase
      cfg_we <= 1'b0;
      for (int n = 0; n < 22; n++) begin
        c = rand_cmd();
        send_cmd(c);
      end
      drain();
    end

    $display("run: %0d commands, %0d status transfers checked over 6 settings",
             items_sent, stat_seen);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
